[rtl/core/assert_macros.svh]
// Concurrent assertion macros used by the opd_checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/opd_pkg.sv]
// Shared types, constants and a helper function of the Ogg page deframer
package opd_pkg;

    localparam int MAX_SEGMENTS = 255;
    localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    localparam int HPOS_W = 5;
    localparam logic [HPOS_W-1:0] CAPTURE_LEN = 5'd4;
    localparam logic [HPOS_W-1:0] SERIAL_FIRST = 5'd14;
    localparam logic [HPOS_W-1:0] SERIAL_LAST = 5'd17;
    localparam logic [HPOS_W-1:0] COUNT_POS = 5'd26;

    localparam logic [7:0] FULL_SEGMENT = 8'd255;

    typedef struct packed {
        logic [7:0] data;
        logic       sos;
        logic       zero;
    } t_item;

    typedef struct packed {
        logic [7:0] len;
        logic [7:0] runs;
    } t_record;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] packet_byte;
        logic       byte_ends_packet;
        logic [7:0] boundaries_after;
        logic       status;
    } t_result;

    function automatic logic [7:0] capture_byte(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0: c = 8'h4F;
            2'd1: c = 8'h67;
            2'd2: c = 8'h67;
            2'd3: c = 8'h53;
            default: c = 8'h4F;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/opd_in_if.sv]
// Input byte channel of the Ogg page deframer
interface opd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       start_of_stream;

    modport source (output valid, output stream_byte, output start_of_stream, input ready);
    modport sink (input valid, input stream_byte, input start_of_stream, output ready);
endinterface

[rtl/core/opd_out_if.sv]
// Result channel of the Ogg page deframer
interface opd_out_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] packet_byte;
    logic       byte_ends_packet;
    logic [7:0] boundaries_after;
    logic       status;

    modport source (
        output valid, output has_byte, output packet_byte, output byte_ends_packet,
        output boundaries_after, output status, input ready
    );
    modport sink (
        input valid, input has_byte, input packet_byte, input byte_ends_packet,
        input boundaries_after, input status, output ready
    );
endinterface

[rtl/core/opd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data
module opd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 255,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/opd_front.sv]
// Front end: accept stream bytes, tag them and hold them in a short queue
module opd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    opd_in_if.sink         i_in,
    output opd_pkg::t_item o_item,
    output logic           o_item_valid,
    input  logic           i_pop
);

    opd_pkg::t_item r_slot [opd_pkg::QUEUE_DEPTH];
    logic [opd_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [opd_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [opd_pkg::QUEUE_CW-1:0] r_count, n_count;
    logic           w_push;
    opd_pkg::t_item w_tagged;

    assign i_in.ready = (r_count != opd_pkg::QUEUE_CW'(opd_pkg::QUEUE_DEPTH));
    assign w_push = i_in.valid && i_in.ready;

    always_comb begin
        w_tagged.data = i_in.stream_byte;
        w_tagged.sos  = i_in.start_of_stream;
        w_tagged.zero = (i_in.stream_byte == 8'd0);
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == opd_pkg::QUEUE_AW'(opd_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == opd_pkg::QUEUE_AW'(opd_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_tagged;
        end
    end

    assign o_item       = r_slot[r_rd_ptr];
    assign o_item_valid = (r_count != '0);

endmodule

[rtl/core/opd_parser.sv]
// Back end: page header parse, lacing table capture and payload release
module opd_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  opd_pkg::t_item i_item,
    input  logic           i_item_valid,
    output logic           o_pop,
    opd_out_if.source      o_out
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_TABLE,
        PH_DATA,
        PH_STOP
    } t_phase;

    t_phase r_phase, n_phase, s_phase;
    logic [opd_pkg::HPOS_W-1:0] r_hpos, n_hpos, s_hpos;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_lserial, n_lserial;
    logic        r_locked, n_locked, s_locked;
    logic        r_matches, n_matches;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_seg_idx, n_seg_idx;
    logic [7:0]  r_lead, n_lead;
    logic        r_anchor_valid, n_anchor_valid;
    logic [7:0]  r_anc_len, n_anc_len;
    logic [7:0]  r_anc_runs, n_anc_runs;
    logic [opd_pkg::SEG_AW-1:0] r_rec_wr, n_rec_wr;
    logic [opd_pkg::SEG_AW-1:0] r_idx, n_idx;
    logic [7:0]  r_pos, n_pos;
    logic        r_fwd, n_fwd;
    opd_pkg::t_record r_fwd_data;
    logic        r_out_valid, n_out_valid;
    opd_pkg::t_result r_out, n_out;

    opd_pkg::t_result w_res;
    opd_pkg::t_record w_ram_q, w_rec, w_wr_data;
    logic        w_wr_en;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'd255) ? v : v + 8'd1;
    endfunction

    assign o_pop = i_item_valid && (!r_out_valid || o_out.ready);

    opd_ram #(
        .WIDTH ($bits(opd_pkg::t_record)),
        .DEPTH (opd_pkg::MAX_SEGMENTS)
    ) u_lacing_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_rec_wr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (n_idx),
        .o_rd_data (w_ram_q)
    );

    always_comb begin
        n_phase        = r_phase;
        n_hpos         = r_hpos;
        n_acc          = r_acc;
        n_lserial      = r_lserial;
        n_locked       = r_locked;
        n_matches      = r_matches;
        n_count        = r_count;
        n_seg_idx      = r_seg_idx;
        n_lead         = r_lead;
        n_anchor_valid = r_anchor_valid;
        n_anc_len      = r_anc_len;
        n_anc_runs     = r_anc_runs;
        n_rec_wr       = r_rec_wr;
        n_idx          = r_idx;
        n_pos          = r_pos;
        w_res          = '0;
        w_wr_en        = 1'b0;
        w_wr_data.len  = r_anc_len;
        w_wr_data.runs = r_anc_runs;

        s_phase  = i_item.sos ? PH_HEADER : r_phase;
        s_hpos   = i_item.sos ? '0 : r_hpos;
        s_locked = i_item.sos ? 1'b0 : r_locked;

        if (r_idx == r_rec_wr) begin
            w_rec.len  = r_anc_len;
            w_rec.runs = r_anc_runs;
        end else begin
            w_rec = r_fwd ? r_fwd_data : w_ram_q;
        end

        if (o_pop) begin
            n_phase  = s_phase;
            n_hpos   = s_hpos;
            n_locked = s_locked;
            case (s_phase)
                PH_HEADER: begin
                    if (s_hpos < opd_pkg::CAPTURE_LEN) begin
                        if (i_item.data != opd_pkg::capture_byte(s_hpos[1:0])) begin
                            n_phase = PH_STOP;
                        end
                    end else if (s_hpos >= opd_pkg::SERIAL_FIRST &&
                                 s_hpos <= opd_pkg::SERIAL_LAST) begin
                        n_acc = {i_item.data, r_acc[31:8]};
                    end
                    if (n_phase == PH_HEADER) begin
                        if (s_hpos == opd_pkg::COUNT_POS) begin
                            n_count = i_item.data;
                            n_hpos  = '0;
                            if ({1'b0, i_item.data} > 9'(opd_pkg::MAX_SEGMENTS)) begin
                                n_phase = PH_STOP;
                            end else begin
                                if (!s_locked) begin
                                    n_lserial = r_acc;
                                    n_locked  = 1'b1;
                                end
                                n_matches = !s_locked || (r_acc == r_lserial);
                                if (!i_item.zero) begin
                                    n_phase        = PH_TABLE;
                                    n_seg_idx      = '0;
                                    n_lead         = '0;
                                    n_anchor_valid = 1'b0;
                                    n_rec_wr       = '0;
                                end
                            end
                        end else begin
                            n_hpos = s_hpos + 1'b1;
                        end
                    end
                end
                PH_TABLE: begin
                    n_seg_idx = r_seg_idx + 8'd1;
                    if (i_item.zero) begin
                        if (r_anchor_valid) begin
                            n_anc_runs = sat_inc(r_anc_runs);
                        end else begin
                            n_lead = sat_inc(r_lead);
                        end
                    end else begin
                        if (r_anchor_valid) begin
                            w_wr_en  = 1'b1;
                            n_rec_wr = r_rec_wr + 1'b1;
                        end
                        n_anc_len      = i_item.data;
                        n_anc_runs     = '0;
                        n_anchor_valid = 1'b1;
                    end
                    if (r_seg_idx == r_count - 8'd1) begin
                        w_res.boundaries_after = r_matches ? n_lead : 8'd0;
                        if (!n_anchor_valid) begin
                            n_phase = PH_HEADER;
                            n_hpos  = '0;
                        end else begin
                            n_phase = PH_DATA;
                            n_idx   = '0;
                            n_pos   = '0;
                        end
                    end
                end
                PH_DATA: begin
                    w_res.has_byte    = r_matches;
                    w_res.packet_byte = r_matches ? i_item.data : 8'd0;
                    if (r_pos + 8'd1 == w_rec.len) begin
                        w_res.byte_ends_packet =
                            r_matches && (w_rec.len != opd_pkg::FULL_SEGMENT);
                        w_res.boundaries_after = r_matches ? w_rec.runs : 8'd0;
                        if (r_idx == r_rec_wr) begin
                            n_phase = PH_HEADER;
                            n_hpos  = '0;
                        end else begin
                            n_idx = r_idx + 1'b1;
                            n_pos = '0;
                        end
                    end else begin
                        n_pos = r_pos + 8'd1;
                    end
                end
                PH_STOP: begin
                    n_phase = PH_STOP;
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
            w_res.status = (n_phase == PH_STOP);
        end

        n_fwd       = w_wr_en && (r_rec_wr == n_idx);
        n_out       = o_pop ? w_res : r_out;
        n_out_valid = o_pop ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_hpos         <= '0;
            r_locked       <= 1'b0;
            r_matches      <= 1'b0;
            r_count        <= '0;
            r_seg_idx      <= '0;
            r_lead         <= '0;
            r_anchor_valid <= 1'b0;
            r_rec_wr       <= '0;
            r_idx          <= '0;
            r_pos          <= '0;
            r_fwd          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_hpos         <= n_hpos;
            r_locked       <= n_locked;
            r_matches      <= n_matches;
            r_count        <= n_count;
            r_seg_idx      <= n_seg_idx;
            r_lead         <= n_lead;
            r_anchor_valid <= n_anchor_valid;
            r_rec_wr       <= n_rec_wr;
            r_idx          <= n_idx;
            r_pos          <= n_pos;
            r_fwd          <= n_fwd;
            r_out_valid    <= n_out_valid;
        end
        r_acc      <= n_acc;
        r_lserial  <= n_lserial;
        r_anc_len  <= n_anc_len;
        r_anc_runs <= n_anc_runs;
        r_fwd_data <= w_wr_data;
        r_out      <= n_out;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.has_byte         = r_out.has_byte;
    assign o_out.packet_byte      = r_out.packet_byte;
    assign o_out.byte_ends_packet = r_out.byte_ends_packet;
    assign o_out.boundaries_after = r_out.boundaries_after;
    assign o_out.status           = r_out.status;

endmodule

[rtl/core/ogg_page_packet_deframer.sv]
// Output: a result is registered; the queue holds its byte until the parser pops it into
// the output register.
// Throughput: one byte per cycle unless the output stalls; the lacing RAM holds nonzero
// segment records but the last, is read one record ahead, so a new segment starts with no gap.
// Reset: synchronous, active low; clears the parser, queue and output valid.
// The lacing RAM is not cleared; every record is written before a page reads it.
module ogg_page_packet_deframer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    opd_in_if.sink    i_in,
    opd_out_if.source o_out
);

    opd_pkg::t_item w_item;
    logic           w_item_valid;
    logic           w_pop;

    opd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_pop        (w_pop)
    );

    opd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_pop        (w_pop),
        .o_out        (o_out)
    );

endmodule

[rtl/core/opd_checker.sv]
// Port-level assertion checker for the Ogg page deframer, with its bind
`include "assert_macros.svh"

module opd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_has_byte,
    input logic [7:0] i_packet_byte,
    input logic       i_byte_ends_packet,
    input logic [7:0] i_boundaries_after,
    input logic       i_status
);

    logic [18:0] w_out_bits;

    assign w_out_bits = {i_has_byte, i_packet_byte, i_byte_ends_packet,
                         i_boundaries_after, i_status};

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(w_out_bits), "stalled transaction changed")

    `ASSERT_IMPLIES(a_stop_quiet, i_clk, i_rst_n, i_out_valid && i_status, !i_has_byte && i_packet_byte == 8'd0 && !i_byte_ends_packet && i_boundaries_after == 8'd0, "stopped transaction carries data")

    `ASSERT_IMPLIES(a_no_byte_quiet, i_clk, i_rst_n, i_out_valid && !i_has_byte, i_packet_byte == 8'd0 && !i_byte_ends_packet, "packet fields set without payload")

endmodule

bind ogg_page_packet_deframer opd_checker u_opd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_has_byte         (o_out.has_byte),
    .i_packet_byte      (o_out.packet_byte),
    .i_byte_ends_packet (o_out.byte_ends_packet),
    .i_boundaries_after (o_out.boundaries_after),
    .i_status           (o_out.status)
);
